[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file wts_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that c holds in the cycle where a holds
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: a |-> c");

// check that c holds in the cycle after a holds
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: a |=> c");

`endif

[hw/rtl/wts_pkg.sv]
// Package for the wildcard text search core: types, constants and byte tests.
// No dependencies; used by wts_cell, wts_out_fifo and wildcard_text_search_core.
`default_nettype none

package wts_pkg;

    localparam int PAT_BYTES = 20;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_WILDCARD = 8'h60;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_Z    = 8'h7A;
    localparam logic [7:0] CASE_MASK   = 8'hDF;
    localparam logic [15:0] SAT_MAX    = 16'hFFFF;

    localparam logic [2:0] REG_PAT_LOW    = 3'd0;
    localparam logic [2:0] REG_PAT_MID    = 3'd1;
    localparam logic [2:0] REG_PAT_HIGH   = 3'd2;
    localparam logic [2:0] REG_PAT_LEN    = 3'd3;
    localparam logic [2:0] REG_FOLD_CASE  = 3'd4;
    localparam logic [2:0] REG_WHOLE_WORD = 3'd5;
    localparam logic [2:0] REG_OCC_TARGET = 3'd6;
    localparam logic [2:0] REG_START_LINE = 3'd7;

    typedef logic [PAT_BYTES-1:0][7:0] t_pat;

    typedef struct packed {
        logic        valid;
        logic        presep;
        logic [7:0]  text;
        logic [15:0] line;
        logic [15:0] offset;
    } t_cell;

    typedef struct packed {
        logic        hit;
        logic [15:0] offset;
        logic [15:0] line;
        logic [15:0] occ;
        logic        target;
        logic        failed;
        logic        last;
    } t_result;

    function automatic logic [7:0] pat_byte(input t_pat p, input logic [6:0] k);
        logic [7:0] r;
        r = 8'h00;
        if (k < 7'(PAT_BYTES)) begin
            r = p[k[4:0]];
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b <= CH_SPACE) || b[7];
    endfunction

    function automatic logic is_break(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic byte_ok(input logic [7:0] t, input logic [7:0] p,
                                     input logic fold);
        logic [7:0] pp;
        logic [8:0] d;
        logic       r;
        pp = p;
        if (fold && (p >= CH_LOW_A) && (p <= CH_LOW_Z)) begin
            pp = p & CASE_MASK;
        end
        d = {t[7], t} - {pp[7], pp};
        if (pp == CH_WILDCARD) begin
            r = 1'b1;
        end else if (fold) begin
            r = (d == 9'd0) || (d == 9'd32);
        end else begin
            r = (d == 9'd0);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/wts_cell.sv]
// One window position: holds a text byte with its line, offset and separator
// flag, hands it to the next position and compares it to its two pattern bytes.
// Depends on wts_pkg.
`default_nettype none

module wts_cell #(
    parameter int IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire logic           i_clear,
    input  wire wts_pkg::t_cell i_prev,
    input  wire logic [4:0]     i_len,
    input  wire wts_pkg::t_pat  i_pattern,
    input  wire logic           i_fold,
    output wts_pkg::t_cell      o_cell,
    output logic                o_ok_a,
    output logic                o_ok_b
);
    import wts_pkg::*;

    localparam logic [6:0] POS = 7'(IDX);

    t_cell      r_cell;
    logic [6:0] len7;
    logic [6:0] k_a;
    logic [6:0] k_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid  <= 1'b0;
            r_cell.presep <= 1'b1;
        end else if (i_shift) begin
            r_cell.text   <= i_prev.text;
            r_cell.line   <= i_prev.line;
            r_cell.offset <= i_prev.offset;
            if (i_clear) begin
                r_cell.valid  <= 1'b0;
                r_cell.presep <= 1'b1;
            end else begin
                r_cell.valid  <= i_prev.valid;
                r_cell.presep <= i_prev.presep;
            end
        end
    end

    always_comb begin
        len7   = {2'b00, i_len};
        k_a    = len7 - 7'd1 - POS;
        k_b    = len7 - POS;
        o_ok_a = (POS >= len7) ||
                 (r_cell.valid && byte_ok(r_cell.text, pat_byte(i_pattern, k_a), i_fold));
        o_ok_b = (POS == 7'd0) || (POS > len7) ||
                 (r_cell.valid && byte_ok(r_cell.text, pat_byte(i_pattern, k_b), i_fold));
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

[hw/rtl/wts_out_fifo.sv]
// Result queue between the match evaluation and the output channel:
// takes up to two results per cycle, gives one per transfer.
// Depends on wts_pkg.
`default_nettype none

module wts_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push0,
    input  wire logic             i_push1,
    input  wire wts_pkg::t_result i_data0,
    input  wire wts_pkg::t_result i_data1,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output wts_pkg::t_result      o_data,
    output logic [2:0]            o_count
);
    import wts_pkg::*;

    t_result               r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr;
    logic [OUT_PTR_W-1:0]  r_rd;
    logic [2:0]            r_cnt;
    logic                  pop;
    logic [1:0]            n_push;

    assign pop    = o_valid && i_ready;
    assign n_push = {1'b0, i_push0} + {1'b0, i_push1};

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[r_wr + OUT_PTR_W'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OUT_PTR_W'(n_push);
            r_rd  <= r_rd + OUT_PTR_W'(pop);
            r_cnt <= r_cnt + 3'(n_push) - 3'(pop);
        end
    end

    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

[hw/rtl/wildcard_text_search_core.sv]
// Wildcard text search core: a chain of window cells, match evaluation and
// a four-entry result queue. Depends on wts_pkg, wts_cell and wts_out_fifo.
// Results: each is evaluated once its byte has entered the window, then is
// queued and offered. Throughput: one byte per cycle; a byte with two hits
// gives two output results, and the queue holds off input when nearly full.
// Reset: synchronous; window emptied, counters zero, registers at defaults.
`default_nettype none

module wildcard_text_search_core #(
    parameter int MAX_PATTERN = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_first_of_text,
    input  wire logic        i_last_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_match_hit,
    output logic [15:0]      o_match_offset,
    output logic [15:0]      o_match_line,
    output logic [15:0]      o_occurrence_number,
    output logic             o_target_reached,
    output logic             o_search_failed,
    output logic             o_last_result
);
    import wts_pkg::*;

    localparam int DEPTH = MAX_PATTERN + 1;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP   = (MAX_PATTERN < 31) ? MAX_PATTERN : 31;
    localparam logic [4:0] CAP5 = 5'(CAP);

    t_pat        r_pattern;
    logic [4:0]  r_plen;
    logic        r_fold;
    logic        r_whole;
    logic [15:0] r_target;
    logic [15:0] r_start_line;

    logic        r_pend;
    logic        r_pend_last;
    logic        r_prev_last;
    logic [15:0] r_line;
    logic [15:0] r_off;
    logic [15:0] r_hits;
    logic        r_done;

    t_cell       cells [DEPTH];
    logic [DEPTH-1:0] ok_a;
    logic [DEPTH-1:0] ok_b;
    t_cell       head;

    logic        accept;
    logic        fire;
    logic        eff_first;
    logic [15:0] base_line;
    logic [15:0] base_off;
    logic [4:0]  len;
    logic [SW-1:0] sel_a;
    logic [SW-1:0] sel_b;
    t_cell       slot_a;
    t_cell       slot_b;
    logic        raw_a;
    logic        raw_b;
    logic        hit_a;
    logic        hit_b;
    logic [15:0] h1;
    logic [15:0] h2;
    logic [15:0] occ_a;
    logic        tr_b;
    logic        tr_a;
    logic        done_b;
    logic        done_f;
    t_result     res_a;
    t_result     res_b;
    t_result     e0;
    t_result     e1;
    logic [1:0]  n_res;
    logic [2:0]  q_count;
    t_result     q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_plen       <= 5'd1;
            r_fold       <= 1'b0;
            r_whole      <= 1'b0;
            r_target     <= 16'd1;
            r_start_line <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAT_LOW:    r_pattern[7:0]   <= i_cfg_data;
                REG_PAT_MID:    r_pattern[15:8]  <= i_cfg_data;
                REG_PAT_HIGH:   r_pattern[19:16] <= i_cfg_data[31:0];
                REG_PAT_LEN:    r_plen           <= i_cfg_data[4:0];
                REG_FOLD_CASE:  r_fold           <= i_cfg_data[0];
                REG_WHOLE_WORD: r_whole          <= i_cfg_data[0];
                REG_OCC_TARGET: r_target         <= i_cfg_data[15:0];
                REG_START_LINE: r_start_line     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign fire       = r_pend && (q_count <= 3'd2);
    assign o_in_ready = !r_pend || fire;
    assign accept     = i_in_valid && o_in_ready;
    assign eff_first  = i_first_of_text || r_prev_last;
    assign base_line  = i_first_of_text ? r_start_line : r_line;
    assign base_off   = i_first_of_text ? 16'd0 : r_off;

    always_comb begin
        head.valid  = 1'b1;
        head.text   = i_text_byte;
        head.line   = base_line;
        head.offset = base_off;
        head.presep = (eff_first || !cells[0].valid) ? 1'b1 : is_sep(cells[0].text);
    end

    assign len = (r_plen > CAP5) ? CAP5 : r_plen;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        wts_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (accept),
            .i_clear   ((g != 0) && eff_first),
            .i_prev    ((g == 0) ? head : cells[(g == 0) ? 0 : g - 1]),
            .i_len     (len),
            .i_pattern (r_pattern),
            .i_fold    (r_fold),
            .o_cell    (cells[g]),
            .o_ok_a    (ok_a[g]),
            .o_ok_b    (ok_b[g])
        );
    end

    always_comb begin
        sel_a  = SW'(len - 5'd1);
        sel_b  = SW'(len);
        slot_a = cells[sel_a];
        slot_b = cells[sel_b];

        raw_a = (len != 5'd0) && (&ok_a) && slot_a.valid && !is_break(slot_a.text) &&
                (!r_whole || (r_pend_last && slot_a.presep));
        raw_b = (len != 5'd0) && r_whole && is_sep(cells[0].text) && (&ok_b) &&
                slot_b.valid && !is_break(slot_b.text) && slot_b.presep;

        h1 = (r_hits == SAT_MAX) ? r_hits : r_hits + 16'd1;
        h2 = (h1 == SAT_MAX) ? h1 : h1 + 16'd1;

        hit_b  = !r_done && raw_b;
        tr_b   = (h1 == r_target);
        done_b = r_done || (hit_b && tr_b);
        hit_a  = !done_b && raw_a;
        occ_a  = hit_b ? h2 : h1;
        tr_a   = (occ_a == r_target);
        done_f = done_b || (hit_a && tr_a);

        res_b = '{hit: 1'b1, offset: slot_b.offset, line: slot_b.line, occ: h1,
                  target: tr_b, failed: 1'b0, last: 1'b0};
        res_a = '{hit: 1'b1, offset: slot_a.offset, line: slot_a.line, occ: occ_a,
                  target: tr_a, failed: 1'b0, last: 1'b0};

        e0    = hit_b ? res_b : res_a;
        e1    = res_a;
        n_res = {1'b0, hit_b} + {1'b0, hit_a};

        if (r_pend_last && !done_f) begin
            if (n_res == 2'd0) begin
                e0    = '0;
                n_res = 2'd1;
            end
            if (n_res == 2'd2) begin
                e1.failed = 1'b1;
            end else begin
                e0.failed = 1'b1;
            end
        end
        if (n_res == 2'd2) begin
            e1.last = 1'b1;
        end else begin
            e0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_prev_last <= 1'b0;
            r_line      <= 16'd0;
            r_off       <= 16'd0;
            r_hits      <= 16'd0;
            r_done      <= 1'b0;
        end else begin
            if (accept) begin
                r_pend      <= 1'b1;
                r_pend_last <= i_last_of_text;
                r_prev_last <= i_last_of_text;
                if (i_last_of_text) begin
                    r_line <= r_start_line;
                    r_off  <= 16'd0;
                end else begin
                    r_line <= ((i_text_byte == CH_LF) && (base_line != SAT_MAX)) ?
                              base_line + 16'd1 : base_line;
                    r_off  <= (base_off == SAT_MAX) ? base_off : base_off + 16'd1;
                end
            end else if (fire) begin
                r_pend <= 1'b0;
            end
            if (accept && eff_first) begin
                r_hits <= 16'd0;
                r_done <= 1'b0;
            end else if (fire) begin
                r_hits <= hit_b ? (hit_a ? h2 : h1) : (hit_a ? h1 : r_hits);
                r_done <= done_f;
            end
        end
    end

    wts_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (fire && (n_res != 2'd0)),
        .i_push1 (fire && (n_res == 2'd2)),
        .i_data0 (e0),
        .i_data1 (e1),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_match_hit         = q_data.hit;
    assign o_match_offset      = q_data.offset;
    assign o_match_line        = q_data.line;
    assign o_occurrence_number = q_data.occ;
    assign o_target_reached    = q_data.target;
    assign o_search_failed     = q_data.failed;
    assign o_last_result       = q_data.last;

endmodule

`default_nettype wire

[hw/rtl/wts_checker.sv]
// Port-level checker for the wildcard text search core, bound to the top.
// Depends on assert_macros.svh and wildcard_text_search_core.
`default_nettype none
`include "assert_macros.svh"

module wts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_match_hit,
    input wire logic [15:0] o_match_offset,
    input wire logic        o_target_reached,
    input wire logic        o_search_failed,
    input wire logic        o_last_result
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_match_offset))
    `ASSERT_IMPLY(a_fail_is_final, i_clk, i_rst_n, o_out_valid && o_search_failed, o_last_result)
    `ASSERT_IMPLY(a_target_on_hit, i_clk, i_rst_n, o_out_valid && o_target_reached, o_match_hit)
    `ASSERT_IMPLY(a_miss_is_fail, i_clk, i_rst_n, o_out_valid && !o_match_hit, o_search_failed)

endmodule

bind wildcard_text_search_core wts_checker u_wts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_match_hit      (o_match_hit),
    .o_match_offset   (o_match_offset),
    .o_target_reached (o_target_reached),
    .o_search_failed  (o_search_failed),
    .o_last_result    (o_last_result)
);

`default_nettype wire
